// ----- hw/rtl/scba_pkg.sv -----
// Shared types, class layout tables and layout helper functions for the size class allocator.
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

   localparam int unsigned WORD_BITS_DEF    = 64;
   localparam int unsigned BITMAP_WORDS_DEF = 146;
   localparam int unsigned NUM_CLASSES_DEF  = 12;
   localparam int unsigned MAX_CLASSES      = 16;

   localparam int unsigned ADDR_W  = 25;   // byte offset width
   localparam int unsigned SIZE_W  = 32;   // request size width
   localparam int unsigned CLASS_W = 4;    // class index width
   localparam int unsigned IDX_W   = 12;   // chunk index inside one class
   localparam int unsigned WNUM_W  = 12;   // global bitmap word number
   localparam int unsigned LOG_W   = 5;
   localparam int unsigned ENT_W   = 13;

   typedef logic [MAX_CLASSES-1:0][LOG_W-1:0]  log_tab_type;
   typedef logic [MAX_CLASSES-1:0][ENT_W-1:0]  ent_tab_type;
   typedef logic [MAX_CLASSES-1:0][ADDR_W-1:0] addr_tab_type;
   typedef logic [MAX_CLASSES-1:0][WNUM_W-1:0] word_tab_type;

   // Chunk size of each class as a power of two; classes 12 to 15 are empty.
   localparam log_tab_type CLASS_LOG = {
      5'd0, 5'd0, 5'd0, 5'd0, 5'd19, 5'd13, 5'd12, 5'd11,
      5'd10, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3
   };

   localparam ent_tab_type CLASS_ENTRIES = {
      13'd0, 13'd0, 13'd0, 13'd0, 13'd32, 13'd64, 13'd256, 13'd256,
      13'd256, 13'd256, 13'd256, 13'd256, 13'd512, 13'd1024, 13'd2048, 13'd4096
   };

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_RESOURCE = 2'd1,
      STATUS_BAD_ADDRESS = 2'd2,
      STATUS_DOUBLE_FREE = 2'd3
   } status_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Decoded request, handed from the class decoder to the sequencer.
   typedef struct packed {
      logic               is_free;
      logic               hit;         // class found (allocate) or address in range (free)
      logic [CLASS_W-1:0] cls;
      logic [IDX_W-1:0]   idx;         // chunk index for a free
      logic [WNUM_W-1:0]  first_word;  // first bitmap word of the class
      logic [WNUM_W-1:0]  scan_words;  // words an allocate may look at
   } dec_type;

   // Byte offset where each class region starts; regions sit back to back.
   function automatic addr_tab_type class_bases(input int unsigned n);
      addr_tab_type       t;
      logic [ADDR_W-1:0]  off;
      off = '0;
      for (int unsigned c = 0; c < MAX_CLASSES; c++) begin
         t[c] = off;
         if (c < n) begin
            off = off + (ADDR_W'(CLASS_ENTRIES[c]) << CLASS_LOG[c]);
         end
      end
      return t;
   endfunction

   // Byte offset just past each class region; a disabled class has an empty region.
   function automatic addr_tab_type class_ends(input int unsigned n);
      addr_tab_type t;
      addr_tab_type b;
      b = class_bases(n);
      for (int unsigned c = 0; c < MAX_CLASSES; c++) begin
         if (c < n) begin
            t[c] = b[c] + (ADDR_W'(CLASS_ENTRIES[c]) << CLASS_LOG[c]);
         end else begin
            t[c] = b[c];
         end
      end
      return t;
   endfunction

   // First bitmap word of each class, from the per-class word counts.
   function automatic word_tab_type class_first_words(input word_tab_type cnt,
                                                      input int unsigned n);
      word_tab_type      t;
      logic [WNUM_W-1:0] w;
      w = '0;
      for (int unsigned c = 0; c < MAX_CLASSES; c++) begin
         t[c] = w;
         if (c < n) begin
            w = w + cnt[c];
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scba_bitmap_ram.sv -----
// Usage bitmap storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module scba_bitmap_ram #(
   parameter int unsigned WORD_BITS    = scba_pkg::WORD_BITS_DEF,
   parameter int unsigned BITMAP_WORDS = scba_pkg::BITMAP_WORDS_DEF,
   localparam int unsigned WA_W        = $clog2(BITMAP_WORDS)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [WA_W-1:0]      wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [WA_W-1:0]      rd_addr,
   output logic      [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/scba_class_decode.sv -----
// Request decoder: picks the class of an allocate or the region of a free, registered.
`timescale 1ns / 1ps
`default_nettype none

module scba_class_decode #(
   parameter int unsigned WORD_BITS    = scba_pkg::WORD_BITS_DEF,
   parameter int unsigned BITMAP_WORDS = scba_pkg::BITMAP_WORDS_DEF,
   parameter int unsigned NUM_CLASSES  = scba_pkg::NUM_CLASSES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic                          kind,
   input  wire logic [scba_pkg::SIZE_W-1:0]   request_size,
   input  wire logic [scba_pkg::ADDR_W-1:0]   free_address,
   output scba_pkg::dec_type                  dec
);

   localparam int unsigned WNW = scba_pkg::WNUM_W;

   // Words per class, each class rounded up to whole words.
   localparam scba_pkg::word_tab_type CLASS_WORDS = {
      WNW'((int'(scba_pkg::CLASS_ENTRIES[15]) + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[14]) + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[13]) + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[12]) + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[11]) + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[10]) + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[9])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[8])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[7])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[6])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[5])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[4])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[3])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[2])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[1])  + WORD_BITS - 1) / WORD_BITS),
      WNW'((int'(scba_pkg::CLASS_ENTRIES[0])  + WORD_BITS - 1) / WORD_BITS)
   };

   localparam scba_pkg::word_tab_type FIRST_WORD =
      scba_pkg::class_first_words(CLASS_WORDS, NUM_CLASSES);
   localparam scba_pkg::addr_tab_type BASE = scba_pkg::class_bases(NUM_CLASSES);
   localparam scba_pkg::addr_tab_type ENDS = scba_pkg::class_ends(NUM_CLASSES);
   localparam logic [WNW-1:0] TOTAL_WORDS = WNW'(BITMAP_WORDS);

   logic                            fit_hit;
   logic [scba_pkg::CLASS_W-1:0]    fit_cls;
   logic                            rng_hit;
   logic [scba_pkg::CLASS_W-1:0]    rng_cls;
   logic [scba_pkg::ADDR_W-1:0]     rel_off;
   logic [scba_pkg::CLASS_W-1:0]    sel_cls;
   logic [WNW-1:0]                  sel_first;
   logic [WNW-1:0]                  room;
   scba_pkg::dec_type               dec_in;
   scba_pkg::dec_type               dec_ff;

   always_comb begin
      fit_hit = 1'b0;
      fit_cls = '0;
      rng_hit = 1'b0;
      rng_cls = '0;
      // Walk downward so that the lowest matching class is the one kept.
      for (int c = scba_pkg::MAX_CLASSES - 1; c >= 0; c--) begin
         if (c < int'(NUM_CLASSES) && scba_pkg::CLASS_ENTRIES[c] != '0 &&
             {1'b0, request_size} <= (33'd1 << scba_pkg::CLASS_LOG[c])) begin
            fit_hit = 1'b1;
            fit_cls = scba_pkg::CLASS_W'(c);
         end
         if (free_address >= BASE[c] && free_address < ENDS[c]) begin
            rng_hit = 1'b1;
            rng_cls = scba_pkg::CLASS_W'(c);
         end
      end

      rel_off   = free_address - BASE[rng_cls];
      sel_cls   = (kind == scba_pkg::KIND_FREE) ? rng_cls : fit_cls;
      sel_first = FIRST_WORD[sel_cls];
      room      = TOTAL_WORDS - sel_first;

      dec_in.is_free    = (kind == scba_pkg::KIND_FREE);
      dec_in.hit        = (kind == scba_pkg::KIND_FREE) ? rng_hit : fit_hit;
      dec_in.cls        = sel_cls;
      dec_in.idx        = scba_pkg::IDX_W'(rel_off >> scba_pkg::CLASS_LOG[rng_cls]);
      dec_in.first_word = sel_first;
      // Words beyond the end of storage count as full.
      if (sel_first >= TOTAL_WORDS) begin
         dec_in.scan_words = '0;
      end else if (CLASS_WORDS[sel_cls] < room) begin
         dec_in.scan_words = CLASS_WORDS[sel_cls];
      end else begin
         dec_in.scan_words = room;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/scba_free_bit.sv -----
// Finds the lowest clear bit of a bitmap word among the bits that map to real chunks.
`timescale 1ns / 1ps
`default_nettype none

module scba_free_bit #(
   parameter int unsigned WORD_BITS = scba_pkg::WORD_BITS_DEF,
   localparam int unsigned BIT_W    = $clog2(WORD_BITS)
) (
   input  wire logic [WORD_BITS-1:0]          word,
   input  wire logic [scba_pkg::WNUM_W-1:0]   word_ofs,
   input  wire logic [scba_pkg::ENT_W-1:0]    entries,
   output logic                               found,
   output logic [BIT_W-1:0]                   bit_idx
);

   logic [scba_pkg::ENT_W-1:0] first_idx;
   logic [scba_pkg::ENT_W-1:0] limit;

   always_comb begin
      first_idx = scba_pkg::ENT_W'(32'(word_ofs) * WORD_BITS);
      limit     = entries - first_idx;
      found     = 1'b0;
      bit_idx   = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!word[b] && scba_pkg::ENT_W'(b) < limit) begin
            found   = 1'b1;
            bit_idx = BIT_W'(b);
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/size_class_bitmap_allocator.sv -----
// Top level of the size class bitmap allocator: sequencer, bitmap memory and result register.
//
// Requests arrive on the req_ stream, one item per allocate or free; req_tuser
// carries the kind (0 allocate, 1 free). Every item produces exactly one result
// item on the rsp_ stream, with the status in rsp_tuser.
// After reset the block walks through the bitmap memory writing zeros, one word
// per cycle, before req_tready rises for the first time.
// The block works on one item at a time. An allocate reads the bitmap words of
// its class in order until a clear bit is found, up to 64 words for the largest
// class at the default width. The word scan issues one read per cycle on the
// memory's single read port and checks each word when its data returns. A free
// goes through decode, a two-step divide by the word width through a reciprocal
// multiply, one read and one write back.
// The result goes into an output register, so the next request is accepted as
// soon as that register is loaded, even while the receiver holds rsp_tready low.
// A result that finds the register still full waits in the sequencer until the
// receiver takes the earlier one.
`timescale 1ns / 1ps
`default_nettype none

module size_class_bitmap_allocator #(
   parameter int unsigned WORD_BITS    = scba_pkg::WORD_BITS_DEF,
   parameter int unsigned BITMAP_WORDS = scba_pkg::BITMAP_WORDS_DEF,
   parameter int unsigned NUM_CLASSES  = scba_pkg::NUM_CLASSES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] request_size, [56:32] free_address
   input  wire logic [0:0]  req_tuser,   // [0] kind

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [24:0] chunk_address, [28:25] size_class
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   localparam int unsigned WA_W     = $clog2(BITMAP_WORDS);
   localparam int unsigned BIT_W    = $clog2(WORD_BITS);
   localparam int unsigned IDX_W    = scba_pkg::IDX_W;
   localparam int unsigned WNW      = scba_pkg::WNUM_W;
   localparam int unsigned AW       = scba_pkg::ADDR_W;
   localparam int unsigned CW       = scba_pkg::CLASS_W;
   // Reciprocal for the chunk index to word split; exact for any index below 2^IDX_W.
   localparam int unsigned DIV_SHIFT = IDX_W + BIT_W;
   localparam int unsigned MULT_W    = DIV_SHIFT + 1;
   localparam int unsigned PROD_W    = IDX_W + MULT_W;
   localparam logic [MULT_W-1:0] DIV_MULT =
      MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
   localparam logic [WNW-1:0] TOTAL_WORDS = WNW'(BITMAP_WORDS);
   localparam scba_pkg::addr_tab_type BASE = scba_pkg::class_bases(NUM_CLASSES);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_DIV,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [WA_W-1:0]       clr_ff, clr_in;
   logic [WNW-1:0]        iss_ff, iss_in;        // next word offset to read in a scan
   logic                  rdv_ff, rdv_in;        // read data of a scan arrives this cycle
   logic [WNW-1:0]        rofs_ff, rofs_in;      // word offset of that read data
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [IDX_W-1:0]      quo_ff, quo_in;
   logic [WNW-1:0]        word_ff, word_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   scba_pkg::status_type  res_status_ff, res_status_in;
   logic [CW-1:0]         res_cls_ff, res_cls_in;
   logic [IDX_W-1:0]      res_idx_ff, res_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [CW-1:0]         rsp_cls_ff, rsp_cls_in;
   scba_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                  req_accept;
   scba_pkg::dec_type     dec;

   logic                  ram_we;
   logic [WA_W-1:0]       ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic                  ram_re;
   logic [WNW-1:0]        rd_word;
   logic [WORD_BITS-1:0]  ram_rdata;

   logic                  scan_found;
   logic [BIT_W-1:0]      scan_bit;
   logic [WNW-1:0]        free_word;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   scba_class_decode #(
      .WORD_BITS    (WORD_BITS),
      .BITMAP_WORDS (BITMAP_WORDS),
      .NUM_CLASSES  (NUM_CLASSES)
   ) u_decode (
      .clock        (clock),
      .load         (req_accept),
      .kind         (req_tuser[0]),
      .request_size (req_tdata[31:0]),
      .free_address (req_tdata[56:32]),
      .dec          (dec)
   );

   scba_bitmap_ram #(
      .WORD_BITS    (WORD_BITS),
      .BITMAP_WORDS (BITMAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_word[WA_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Lowest free chunk in the word that the scan just read.
   scba_free_bit #(
      .WORD_BITS (WORD_BITS)
   ) u_free_bit (
      .word     (ram_rdata),
      .word_ofs (rofs_ff),
      .entries  (scba_pkg::CLASS_ENTRIES[dec.cls]),
      .found    (scan_found),
      .bit_idx  (scan_bit)
   );

   // Word of a free: class start plus the quotient of the chunk index.
   assign free_word = dec.first_word + WNW'(quo_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      iss_in        = iss_ff;
      rdv_in        = 1'b0;
      rofs_in       = rofs_ff;
      prod_in       = prod_ff;
      quo_in        = quo_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_cls_in    = res_cls_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_cls_in    = rsp_cls_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      rd_word       = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == WA_W'(BITMAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            iss_in = '0;
            if (!dec.hit) begin
               res_status_in = dec.is_free ? scba_pkg::STATUS_BAD_ADDRESS
                                           : scba_pkg::STATUS_NO_RESOURCE;
               res_cls_in    = '0;
               state_in      = ST_FINISH;
            end else if (dec.is_free) begin
               prod_in  = PROD_W'(dec.idx) * PROD_W'(DIV_MULT);
               state_in = ST_DIV;
            end else if (dec.scan_words == '0) begin
               res_status_in = scba_pkg::STATUS_NO_RESOURCE;
               res_cls_in    = dec.cls;
               state_in      = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle; stray reads after a hit are harmless.
            if (iss_ff < dec.scan_words) begin
               ram_re  = 1'b1;
               rd_word = dec.first_word + iss_ff;
               rdv_in  = 1'b1;
               rofs_in = iss_ff;
               iss_in  = iss_ff + 1'b1;
            end
            if (rdv_ff) begin
               if (scan_found) begin
                  ram_we        = 1'b1;
                  ram_waddr     = WA_W'(dec.first_word + rofs_ff);
                  ram_wdata     = ram_rdata | (WORD_BITS'(1) << scan_bit);
                  res_status_in = scba_pkg::STATUS_OK;
                  res_cls_in    = dec.cls;
                  res_idx_in    = IDX_W'(32'(rofs_ff) * WORD_BITS + 32'(scan_bit));
                  state_in      = ST_FINISH;
               end else if (rofs_ff == dec.scan_words - 1'b1) begin
                  res_status_in = scba_pkg::STATUS_NO_RESOURCE;
                  res_cls_in    = dec.cls;
                  state_in      = ST_FINISH;
               end
            end
         end

         ST_DIV: begin
            quo_in   = IDX_W'(prod_ff >> DIV_SHIFT);
            state_in = ST_FREE_RD;
         end

         ST_FREE_RD: begin
            bit_in  = BIT_W'(dec.idx - IDX_W'(32'(quo_ff) * WORD_BITS));
            word_in = free_word;
            if (free_word >= TOTAL_WORDS) begin
               res_status_in = scba_pkg::STATUS_BAD_ADDRESS;
               res_cls_in    = '0;
               state_in      = ST_FINISH;
            end else begin
               ram_re   = 1'b1;
               rd_word  = free_word;
               state_in = ST_FREE_CHK;
            end
         end

         ST_FREE_CHK: begin
            res_cls_in = dec.cls;
            if (!ram_rdata[bit_ff]) begin
               res_status_in = scba_pkg::STATUS_DOUBLE_FREE;
            end else begin
               ram_we        = 1'b1;
               ram_waddr     = word_ff[WA_W-1:0];
               ram_wdata     = ram_rdata & ~(WORD_BITS'(1) << bit_ff);
               res_status_in = scba_pkg::STATUS_OK;
            end
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            // Load the output register once it is empty or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cls_in    = res_cls_ff;
               if (res_status_ff == scba_pkg::STATUS_OK && !dec.is_free) begin
                  rsp_addr_in = BASE[res_cls_ff] +
                                (AW'(res_idx_ff) << scba_pkg::CLASS_LOG[res_cls_ff]);
               end else begin
                  rsp_addr_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iss_ff        <= iss_in;
      rofs_ff       <= rofs_in;
      prod_ff       <= prod_in;
      quo_ff        <= quo_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_cls_ff    <= res_cls_in;
      res_idx_ff    <= res_idx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cls_ff    <= rsp_cls_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_cls_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // The bitmap is only written by the clearing pass, an allocate hit or a real free.
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_SCAN || state_ff == ST_FREE_CHK))
      else $error("bitmap written outside clear, scan or free check");

   // Reads never reach past the end of the storage.
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> rd_word < TOTAL_WORDS)
      else $error("bitmap read beyond storage");

   // An allocate only claims a chunk whose bit was clear.
   a_claim_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && ram_we) |-> !ram_rdata[scan_bit])
      else $error("allocate claimed a chunk already in use");

   // A new result appears only when the sequencer finishes an item.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   // No request is taken while a decoded item is being decided on.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> !req_tready)
      else $error("request accepted during decode");
`endif

endmodule

`default_nettype wire
